// ===== rtl/poc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package poc_pkg;

   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int CHAN_W  = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [DIM_W-1:0]  MAX_DIM    = 13'd4096;
   localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'd0;
   localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;
   localparam logic [15:0]       ROUND_BIAS = 16'd127;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y      = 3'd5;

   typedef struct packed {
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_alpha;
      logic [CHAN_W-1:0] dst_red;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_blue;
      logic [CHAN_W-1:0] dst_alpha;
   } req_payload_type;

   typedef struct packed {
      logic               write_enable;
      logic [COORD_W-1:0] canvas_col;
      logic [COORD_W-1:0] canvas_row;
      logic [CHAN_W-1:0]  out_red;
      logic [CHAN_W-1:0]  out_green;
      logic [CHAN_W-1:0]  out_blue;
      logic [CHAN_W-1:0]  out_alpha;
      logic               frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } pixel_type;

   // clipped placement of the frame on the canvas
   typedef struct packed {
      logic [DIM_W-1:0] frame_w;
      logic [DIM_W-1:0] frame_h;
      logic [DIM_W-1:0] x0;
      logic [DIM_W-1:0] y0;
      logic [DIM_W-1:0] draw_w;
      logic [DIM_W-1:0] draw_h;
   } geom_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               done;
   } pos_type;

endpackage

`default_nettype wire

// ===== rtl/poc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface poc_req_if import poc_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/poc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface poc_rsp_if import poc_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/premultiplied_over_composite_top.sv =====
// an accepted req word reaches rsp through the input stage, then the result stage
// throughput: one pixel per clock; the result stage frees its slot in the cycle rsp is taken,
// so a new req word is accepted in that same cycle; a stalled rsp blocks req once both stages fill
// reset: synchronous, active high; clears the six size/offset registers, the frame
// position counters and both stage valid flags
`timescale 1ns / 1ps
`default_nettype none

module premultiplied_over_composite_top import poc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   poc_req_if.sink                   req_ch,
   poc_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_write_data
);

   geom_type        geom;
   pos_type         pos;
   pixel_type       blended;
   pixel_type       src_pix, dst_pix;

   logic            in_vld_ff, in_vld_in;
   logic            out_vld_ff, out_vld_in;
   req_payload_type in_word_ff, in_word_in;
   pos_type         in_pos_ff, in_pos_in;
   rsp_payload_type out_word_ff, out_word_in;

   logic            accept, out_free, stage_move, write_en;
   logic [DIM_W-1:0] col_sum, row_sum;

   poc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .geom             (geom)
   );

   poc_position u_position (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .frame_w (geom.frame_w),
      .frame_h (geom.frame_h),
      .pos     (pos)
   );

   always_comb begin
      src_pix = '{red: in_word_ff.src_red, green: in_word_ff.src_green,
                  blue: in_word_ff.src_blue, alpha: in_word_ff.src_alpha};
      dst_pix = '{red: in_word_ff.dst_red, green: in_word_ff.dst_green,
                  blue: in_word_ff.dst_blue, alpha: in_word_ff.dst_alpha};
   end

   poc_blend u_blend (
      .src    (src_pix),
      .dst    (dst_pix),
      .result (blended)
   );

   // handshake between the two stages
   always_comb begin
      out_free     = !out_vld_ff || rsp_ch.ready;
      stage_move   = in_vld_ff && out_free;
      req_ch.ready = !in_vld_ff || out_free;
      accept       = req_ch.valid && req_ch.ready;

      in_vld_in  = accept ? 1'b1 : (stage_move ? 1'b0 : in_vld_ff);
      out_vld_in = stage_move ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_vld_ff);
      in_word_in = accept ? req_ch.payload : in_word_ff;
      in_pos_in  = accept ? pos : in_pos_ff;
   end

   // clip and assemble the result word
   always_comb begin
      write_en = ({1'b0, in_pos_ff.col} < geom.draw_w) && ({1'b0, in_pos_ff.row} < geom.draw_h);
      col_sum  = geom.x0 + {1'b0, in_pos_ff.col};
      row_sum  = geom.y0 + {1'b0, in_pos_ff.row};

      out_word_in = out_word_ff;
      if (stage_move) begin
         out_word_in            = '0;
         out_word_in.frame_done = in_pos_ff.done;
         if (write_en) begin
            out_word_in.write_enable = 1'b1;
            out_word_in.canvas_col   = col_sum[COORD_W-1:0];
            out_word_in.canvas_row   = row_sum[COORD_W-1:0];
            out_word_in.out_red      = blended.red;
            out_word_in.out_green    = blended.green;
            out_word_in.out_blue     = blended.blue;
            out_word_in.out_alpha    = blended.alpha;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      in_pos_ff   <= in_pos_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_ch.valid   = out_vld_ff;
   assign rsp_ch.payload = out_word_ff;

`ifndef SYNTHESIS
   a_clipped_word_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_word_ff.write_enable |->
         out_word_ff.canvas_col == '0 && out_word_ff.canvas_row == '0 &&
         out_word_ff.out_red == '0 && out_word_ff.out_green == '0 &&
         out_word_ff.out_blue == '0 && out_word_ff.out_alpha == '0)
      else $error("clipped word carries nonzero coordinates or color");

   a_input_stage_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_ch.ready |=> in_vld_ff && $stable(in_word_ff))
      else $error("input stage lost a word while the result stage was stalled");

   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && pos.done |=> pos.col == '0 && pos.row == '0)
      else $error("position counters did not wrap after the last pixel of a frame");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !in_vld_ff && !out_vld_ff && pos.col == '0 && pos.row == '0)
      else $error("reset left a stage valid or a counter nonzero");
`endif

endmodule

`default_nettype wire

// ===== rtl/poc_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module poc_csr import poc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_write_data,
   output geom_type                  geom
);

   logic [DIM_W-1:0] canvas_w_ff, canvas_h_ff, frame_w_ff, frame_h_ff, offset_x_ff, offset_y_ff;
   logic [DIM_W-1:0] canvas_w_in, canvas_h_in, frame_w_in, frame_h_in, offset_x_in, offset_y_in;
   logic [DIM_W-1:0] cw, ch, ox, oy;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : v;
   endfunction

   function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   always_comb begin
      canvas_w_in = canvas_w_ff;
      canvas_h_in = canvas_h_ff;
      frame_w_in  = frame_w_ff;
      frame_h_in  = frame_h_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_CANVAS_WIDTH:  canvas_w_in = csr_write_data;
            REG_CANVAS_HEIGHT: canvas_h_in = csr_write_data;
            REG_FRAME_WIDTH:   frame_w_in  = csr_write_data;
            REG_FRAME_HEIGHT:  frame_h_in  = csr_write_data;
            REG_OFFSET_X:      offset_x_in = csr_write_data;
            REG_OFFSET_Y:      offset_y_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_w_ff <= '0;
         canvas_h_ff <= '0;
         frame_w_ff  <= '0;
         frame_h_ff  <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else begin
         canvas_w_ff <= canvas_w_in;
         canvas_h_ff <= canvas_h_in;
         frame_w_ff  <= frame_w_in;
         frame_h_ff  <= frame_h_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
      end
   end

   always_comb begin
      cw = sat_dim(canvas_w_ff);
      ch = sat_dim(canvas_h_ff);
      ox = min_dim(sat_dim(offset_x_ff), cw);
      oy = min_dim(sat_dim(offset_y_ff), ch);
      geom.frame_w = sat_dim(frame_w_ff);
      geom.frame_h = sat_dim(frame_h_ff);
      geom.x0      = ox;
      geom.y0      = oy;
      // offsets are clamped to the canvas, so the differences never go negative
      geom.draw_w  = min_dim(geom.frame_w, cw - ox);
      geom.draw_h  = min_dim(geom.frame_h, ch - oy);
   end

endmodule

`default_nettype wire

// ===== rtl/poc_position.sv =====
`timescale 1ns / 1ps
`default_nettype none

module poc_position import poc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [DIM_W-1:0] frame_w,
   input  wire logic [DIM_W-1:0] frame_h,
   output pos_type               pos
);

   logic [COORD_W-1:0] col_count_ff, row_count_ff;
   logic [COORD_W-1:0] col_count_in, row_count_in;
   logic [DIM_W-1:0]   col_next, row_next;
   logic               row_end;

   always_comb begin
      col_next = {1'b0, col_count_ff} + 13'd1;
      row_next = {1'b0, row_count_ff} + 13'd1;
      // a counter at or past a shrunken size also ends its row or frame
      row_end  = col_next >= frame_w;
      pos.col  = col_count_ff;
      pos.row  = row_count_ff;
      pos.done = row_end && (row_next >= frame_h);

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (advance) begin
         if (row_end) begin
            col_count_in = '0;
            row_count_in = pos.done ? '0 : row_next[COORD_W-1:0];
         end else begin
            col_count_in = col_next[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/poc_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none

module poc_blend import poc_pkg::*; (
   input  pixel_type src,
   input  pixel_type dst,
   output pixel_type result
);

   logic [CHAN_W-1:0] inv;

   // floor(x / 255) for x below 65280 (255 * 256): reciprocal estimate, then one correction
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      logic [8:0]  q0;
      logic [16:0] prod;
      logic [16:0] rem;
      logic [8:0]  q;
      sum  = {1'b0, x} + {9'd0, x[15:8]};
      q0   = sum[16:8];
      prod = {q0, 8'd0} - {8'd0, q0};
      rem  = {1'b0, x} - prod;
      q    = (rem >= 17'd255) ? q0 + 9'd1 : q0;
      return q[CHAN_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] s,
                                                    input logic [CHAN_W-1:0] d,
                                                    input logic [CHAN_W-1:0] k);
      logic [15:0] prod;
      prod = d * k;
      return s + div255(prod + ROUND_BIAS);
   endfunction

   always_comb begin
      inv = ALPHA_FULL - src.alpha;
      if (src.alpha == ALPHA_ZERO) begin
         result = dst;
      end else if (src.alpha == ALPHA_FULL) begin
         result       = src;
         result.alpha = ALPHA_FULL;
      end else begin
         result.red   = blend_chan(src.red,   dst.red,   inv);
         result.green = blend_chan(src.green, dst.green, inv);
         result.blue  = blend_chan(src.blue,  dst.blue,  inv);
         result.alpha = blend_chan(src.alpha, dst.alpha, inv);
      end
   end

endmodule

`default_nettype wire
